FILE: rtl/core/mcu_pkg.sv
// Shared types, opcodes and the instruction decoder for the 8-bit executor.
// No dependencies; used by every module under rtl/core.
`default_nettype none

package mcu_pkg;

  localparam logic [7:0] OP_NOP     = 8'h00;
  localparam logic [7:0] OP_ACC_INC = 8'h04;
  localparam logic [7:0] OP_INC_D   = 8'h05;
  localparam logic [7:0] OP_LCALL   = 8'h12;
  localparam logic [7:0] OP_DEC_D   = 8'h15;
  localparam logic [7:0] OP_RET     = 8'h22;
  localparam logic [7:0] OP_ADD_AI  = 8'h24;
  localparam logic [7:0] OP_MOV_AI  = 8'h74;
  localparam logic [7:0] OP_SJMP    = 8'h80;
  localparam logic [7:0] OP_PUSH    = 8'hC0;
  localparam logic [7:0] OP_POP     = 8'hD0;
  localparam logic [7:0] OP_ACC_CLR = 8'hE4;
  localparam logic [7:0] OP_MOV_AD  = 8'hE5;
  localparam logic [7:0] OP_MOV_DA  = 8'hF5;
  localparam logic [7:0] OP_HALT    = 8'hFF;

  // Rn groups, compared on the upper five opcode bits
  localparam logic [4:0] GRP_ADD_AR = 5'b00101;  // 28-2F
  localparam logic [4:0] GRP_MOV_AR = 5'b11101;  // E8-EF
  localparam logic [4:0] GRP_MOV_RA = 5'b11111;  // F8-FE

  localparam logic [7:0] SP_RESET = 8'h07;

  typedef enum logic [1:0] {
    RUN_GO    = 2'd0,
    RUN_HALT  = 2'd1,
    RUN_FAULT = 2'd2
  } run_t;

  typedef enum logic [4:0] {
    K_NOP, K_MOV_AI, K_ADD_AI, K_SJMP, K_INC_A, K_CLR_A, K_HALT,
    K_MOV_AR, K_MOV_RA, K_ADD_AR, K_INC_D, K_DEC_D, K_MOV_AD, K_MOV_DA,
    K_PUSH, K_POP, K_LCALL, K_RET, K_BAD
  } kind_t;

  // LCALL needs two stack writes through the single write port
  typedef enum logic {
    PH_FIRST,
    PH_SECOND
  } phase_t;

  typedef struct packed {
    logic       en;
    logic [7:0] addr_a;
    logic [7:0] addr_b;
  } ram_rd_t;

  typedef struct packed {
    logic       en;
    logic [7:0] addr;
    logic [7:0] data;
  } ram_wr_t;

  function automatic kind_t decode(input logic [7:0] op);
    kind_t k;
    k = K_BAD;
    priority if (op == OP_NOP)            k = K_NOP;
    else if (op == OP_MOV_AI)             k = K_MOV_AI;
    else if (op == OP_ADD_AI)             k = K_ADD_AI;
    else if (op == OP_SJMP)               k = K_SJMP;
    else if (op == OP_ACC_INC)            k = K_INC_A;
    else if (op == OP_ACC_CLR)            k = K_CLR_A;
    else if (op == OP_HALT)               k = K_HALT;
    else if (op[7:3] == GRP_MOV_AR)       k = K_MOV_AR;
    else if (op[7:3] == GRP_MOV_RA)       k = K_MOV_RA;
    else if (op[7:3] == GRP_ADD_AR)       k = K_ADD_AR;
    else if (op == OP_INC_D)              k = K_INC_D;
    else if (op == OP_DEC_D)              k = K_DEC_D;
    else if (op == OP_MOV_AD)             k = K_MOV_AD;
    else if (op == OP_MOV_DA)             k = K_MOV_DA;
    else if (op == OP_PUSH)               k = K_PUSH;
    else if (op == OP_POP)                k = K_POP;
    else if (op == OP_LCALL)              k = K_LCALL;
    else if (op == OP_RET)                k = K_RET;
    else                                  k = K_BAD;
    return k;
  endfunction

endpackage

`default_nettype wire

FILE: rtl/core/mcu_iram.sv
// 256-byte internal RAM: two registered read ports, one write port.
// Per-byte valid bits give the cleared-at-reset view; depends on mcu_pkg.
`default_nettype none

module mcu_iram (
  input  wire              clk,
  input  wire              rst_n,
  input  mcu_pkg::ram_rd_t rd,
  input  mcu_pkg::ram_wr_t wr,
  output logic [7:0]       rd_data_a,
  output logic [7:0]       rd_data_b
);
  import mcu_pkg::*;

  logic [7:0]   mem [256];
  logic [255:0] vld_r;
  logic [7:0]   q_a_r, q_b_r;
  logic         va_r, vb_r;
  logic         fa_r, fb_r;
  logic [7:0]   wd_r;

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
    if (rd.en) begin
      q_a_r <= mem[rd.addr_a];
      q_b_r <= mem[rd.addr_b];
      va_r  <= vld_r[rd.addr_a];
      vb_r  <= vld_r[rd.addr_b];
      // write in the same edge: array returns old data, so bypass it
      fa_r  <= wr.en && (wr.addr == rd.addr_a);
      fb_r  <= wr.en && (wr.addr == rd.addr_b);
      wd_r  <= wr.data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (wr.en) begin
      vld_r[wr.addr] <= 1'b1;
    end
  end

  assign rd_data_a = fa_r ? wd_r : (va_r ? q_a_r : 8'h00);
  assign rd_data_b = fb_r ? wd_r : (vb_r ? q_b_r : 8'h00);

endmodule

`default_nettype wire

FILE: rtl/core/eight_bit_mcu_instruction_executor.sv
// Top level of the 8-bit instruction executor (8051-style subset).
// Depends on mcu_pkg and mcu_iram.
`default_nettype none

// One input transfer is one instruction: the opcode and the two code bytes
// after it. Every instruction yields exactly one result transfer carrying
// the new PC, A, carry, SP and run status. The block is a two-stage loop
// around the internal RAM: the accept cycle issues up to two RAM reads
// (direct byte, Rn, or the stack top pair for RET); the execute stage then
// writes back at most one byte (two for LCALL) and lands the result in the
// output register. Sustained rate is one instruction per clock while the
// result stream does not stall; LCALL holds the stage for its low stack
// byte write, as both stack bytes go through the single RAM write port.
// Written bytes and SP are forwarded into the very next read: no bubbles arise.
// RAM contents read as zero after reset through per-byte valid bits, so
// there is no clearing pass. Once HALT (FF) or an unimplemented opcode is
// executed, later instructions are taken but change nothing; only reset
// restarts the core. register_bank is written through cfg_wr_en/cfg_wr_data
// and should only change while no instruction is in flight.
module eight_bit_mcu_instruction_executor (
  input  wire         clk,
  input  wire         rst_n,
  // configuration: register_bank
  input  wire         cfg_wr_en,
  input  wire  [1:0]  cfg_wr_data,
  // instruction stream
  input  wire         in_tvalid,
  output logic        in_tready,
  input  wire  [23:0] in_tdata,   // opcode[7:0], operand_one[15:8], operand_two[23:16]
  // result stream
  output logic        out_tvalid,
  input  wire         out_tready,
  output logic [39:0] out_tdata   // next_pc[15:0], accumulator_out[23:16],
                                  // carry_out[24], stack_out[32:25],
                                  // run_status[34:33], zero[39:35]
);
  import mcu_pkg::*;

  // configuration and architectural state
  logic [1:0]  bank_r;
  logic [7:0]  acc_r, acc_nxt;
  logic        cy_r, cy_nxt;
  logic [7:0]  sp_r, sp_nxt;
  logic [15:0] pc_r, pc_nxt;
  run_t        stop_r, stop_nxt;

  // execute stage
  logic        s2_valid_r;
  logic [7:0]  s2_op_r, s2_b1_r, s2_b2_r;
  phase_t      phase_r, phase_nxt;
  kind_t       s2_kind;
  logic        running;
  logic        lcall_run;
  logic        s2_fire;
  logic        out_free;
  logic        wr_want;
  logic [7:0]  wr_addr, wr_data;

  // output register
  logic        out_tvalid_r;
  logic [39:0] out_tdata_r;

  // accept side
  logic        accept;
  logic [7:0]  in_op, in_b1;
  kind_t       in_kind;
  logic [7:0]  sp_fwd;

  ram_rd_t     ram_rd;
  ram_wr_t     ram_wr;
  logic [7:0]  ra, rb;

  logic [8:0]  add_sum;
  logic [7:0]  add_src;
  logic [15:0] ret_pc;

  assign in_op   = in_tdata[7:0];
  assign in_b1   = in_tdata[15:8];
  assign in_kind = decode(in_op);

  assign out_free  = !out_tvalid_r || out_tready;
  assign s2_kind   = decode(s2_op_r);
  assign running   = (stop_r == RUN_GO);
  assign lcall_run = s2_valid_r && running && (s2_kind == K_LCALL);
  // LCALL holds the stage for its first (low byte) write
  assign s2_fire   = s2_valid_r && out_free && !(lcall_run && phase_r == PH_FIRST);

  assign in_tready = !s2_valid_r || s2_fire;
  assign accept    = in_tvalid && in_tready;

  // SP as it will be after the instruction now finishing
  assign sp_fwd = s2_fire ? sp_nxt : sp_r;

  // read addresses, issued on the accept edge
  always_comb begin
    ram_rd.en     = accept;
    ram_rd.addr_b = sp_fwd - 8'd1;         // RET low byte
    unique case (in_kind)
      K_POP, K_RET:       ram_rd.addr_a = sp_fwd;
      K_MOV_AR, K_ADD_AR: ram_rd.addr_a = {3'b000, bank_r, in_op[2:0]};
      default:            ram_rd.addr_a = in_b1;
    endcase
  end

  mcu_iram u_iram (
    .clk       (clk),
    .rst_n     (rst_n),
    .rd        (ram_rd),
    .wr        (ram_wr),
    .rd_data_a (ra),
    .rd_data_b (rb)
  );

  assign add_src = (s2_kind == K_ADD_AR) ? ra : s2_b1_r;
  assign add_sum = {1'b0, acc_r} + {1'b0, add_src};
  assign ret_pc  = pc_r + 16'd3;

  // execute
  always_comb begin
    acc_nxt  = acc_r;
    cy_nxt   = cy_r;
    sp_nxt   = sp_r;
    pc_nxt   = pc_r + 16'd1;
    stop_nxt = stop_r;
    wr_want  = 1'b0;
    wr_addr  = s2_b1_r;
    wr_data  = acc_r;
    if (!running) begin
      pc_nxt = pc_r;
    end else begin
      unique case (s2_kind)
        K_NOP: ;
        K_MOV_AI: begin
          acc_nxt = s2_b1_r;
          pc_nxt  = pc_r + 16'd2;
        end
        K_ADD_AI: begin
          acc_nxt = add_sum[7:0];
          cy_nxt  = add_sum[8];
          pc_nxt  = pc_r + 16'd2;
        end
        K_SJMP: pc_nxt = pc_r + 16'd2 + {{8{s2_b1_r[7]}}, s2_b1_r};
        K_INC_A: acc_nxt = acc_r + 8'd1;
        K_CLR_A: acc_nxt = 8'h00;
        K_HALT:  stop_nxt = RUN_HALT;
        K_MOV_AR: acc_nxt = ra;
        K_MOV_RA: begin
          wr_want = 1'b1;
          wr_addr = {3'b000, bank_r, s2_op_r[2:0]};
        end
        K_ADD_AR: begin
          acc_nxt = add_sum[7:0];
          cy_nxt  = add_sum[8];
        end
        K_INC_D: begin
          wr_want = 1'b1;
          wr_data = ra + 8'd1;
          pc_nxt  = pc_r + 16'd2;
        end
        K_DEC_D: begin
          wr_want = 1'b1;
          wr_data = ra - 8'd1;
          pc_nxt  = pc_r + 16'd2;
        end
        K_MOV_AD: begin
          acc_nxt = ra;
          pc_nxt  = pc_r + 16'd2;
        end
        K_MOV_DA: begin
          wr_want = 1'b1;
          pc_nxt  = pc_r + 16'd2;
        end
        K_PUSH: begin
          sp_nxt  = sp_r + 8'd1;
          wr_want = 1'b1;
          wr_addr = sp_r + 8'd1;
          wr_data = ra;
          pc_nxt  = pc_r + 16'd2;
        end
        K_POP: begin
          sp_nxt  = sp_r - 8'd1;
          wr_want = 1'b1;
          wr_data = ra;
          pc_nxt  = pc_r + 16'd2;
        end
        K_LCALL: begin
          sp_nxt  = sp_r + 8'd2;
          wr_want = 1'b1;
          if (phase_r == PH_FIRST) begin
            wr_addr = sp_r + 8'd1;
            wr_data = ret_pc[7:0];
          end else begin
            wr_addr = sp_r + 8'd2;
            wr_data = ret_pc[15:8];
          end
          pc_nxt  = {s2_b1_r, s2_b2_r};
        end
        K_RET: begin
          sp_nxt = sp_r - 8'd2;
          pc_nxt = {ra, rb};
        end
        K_BAD: stop_nxt = RUN_FAULT;
        default: stop_nxt = RUN_FAULT;
      endcase
    end
  end

  // low byte of LCALL goes out on the hold cycle, everything else on fire
  always_comb begin
    ram_wr.en   = s2_valid_r && wr_want &&
                  (s2_fire || (lcall_run && phase_r == PH_FIRST));
    ram_wr.addr = wr_addr;
    ram_wr.data = wr_data;
  end

  // LCALL phase: next state
  always_comb begin
    phase_nxt = phase_r;
    unique case (phase_r)
      PH_FIRST:  if (lcall_run) phase_nxt = PH_SECOND;
      PH_SECOND: if (s2_fire)   phase_nxt = PH_FIRST;
      default:   phase_nxt = PH_FIRST;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_FIRST;
    end else begin
      phase_r <= phase_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bank_r <= 2'd0;
    end else if (cfg_wr_en) begin
      bank_r <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r  <= 8'h00;
      cy_r   <= 1'b0;
      sp_r   <= SP_RESET;
      pc_r   <= 16'h0000;
      stop_r <= RUN_GO;
    end else if (s2_fire) begin
      acc_r  <= acc_nxt;
      cy_r   <= cy_nxt;
      sp_r   <= sp_nxt;
      pc_r   <= pc_nxt;
      stop_r <= stop_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_valid_r <= 1'b0;
    end else if (accept) begin
      s2_valid_r <= 1'b1;
    end else if (s2_fire) begin
      s2_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s2_op_r <= in_op;
      s2_b1_r <= in_b1;
      s2_b2_r <= in_tdata[23:16];
    end
  end

  // output register: frees the execute stage while a result waits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_tvalid_r <= 1'b0;
    end else if (s2_fire) begin
      out_tvalid_r <= 1'b1;
    end else if (out_tready) begin
      out_tvalid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_fire) begin
      out_tdata_r <= {5'b00000, stop_nxt, sp_nxt, cy_nxt, acc_nxt, pc_nxt};
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;

endmodule

`default_nettype wire

FILE: rtl/core/mcu_chk.sv
// Port-level checker for the 8-bit executor, bound to the top level.
// Depends on mcu_pkg and eight_bit_mcu_instruction_executor.
`default_nettype none

module mcu_chk (
  input wire        clk,
  input wire        rst_n,
  input wire        out_tvalid,
  input wire        out_tready,
  input wire [39:0] out_tdata
);
  import mcu_pkg::*;

  logic        out_xfer;
  logic        stopped_r;
  logic [34:0] last_r;

  assign out_xfer = out_tvalid && out_tready;

  // remember the first stopped result; every later one must match it
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stopped_r <= 1'b0;
    end else if (out_xfer && !stopped_r && out_tdata[34:33] != RUN_GO) begin
      stopped_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (out_xfer && !stopped_r) begin
      last_r <= out_tdata[34:0];
    end
  end

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result changed while stalled");

  a_stop_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    out_xfer && stopped_r |-> out_tdata[34:0] == last_r)
    else $error("stopped core changed state");

  a_pad_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[39:35] == 5'b00000)
    else $error("result padding not zero");

  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid right after reset");

endmodule

bind eight_bit_mcu_instruction_executor mcu_chk u_mcu_chk (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);

`default_nettype wire
